@@ design/ulc_pkg.sv @@
package ulc_pkg;

    // Input request: one per microsecond tick.
    typedef struct packed {
        logic start_request;
        logic echo_level;
    } t_in_item;

    // Result: one per input request.
    typedef struct packed {
        logic        trigger_level;
        logic        buzzer_on;
        logic        pump_on;
        logic [1:0]  alert;
        logic        level_valid;
        logic [10:0] level_value;
        logic        busy_res;
    } t_out_item;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LOW_LIMIT      = 3'd0;
    localparam logic [2:0] CFG_FULL_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_ECHO_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_TICKS_PER_UNIT = 3'd3;
    localparam logic [2:0] CFG_TRIGGER_WIDTH  = 3'd4;

    // Configuration reset values.
    localparam logic [10:0] RST_LOW_LIMIT      = 11'd60;
    localparam logic [10:0] RST_FULL_LIMIT     = 11'd300;
    localparam logic [15:0] RST_ECHO_TIMEOUT   = 16'd38000;
    localparam logic [7:0]  RST_TICKS_PER_UNIT = 8'd59;
    localparam logic [7:0]  RST_TRIGGER_WIDTH  = 8'd10;

    // Alert codes.
    localparam logic [1:0] ALERT_NONE = 2'd0;
    localparam logic [1:0] ALERT_LOW  = 2'd1;
    localparam logic [1:0] ALERT_FULL = 2'd2;

    localparam logic [10:0] LEVEL_MAX   = 11'd2047;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

@@ design/ultrasonic_level_controller.sv @@
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+-------------------------------
// in       | input     | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Every input request produces exactly one result, held in the result register once it is accepted.
// A new request can be accepted every cycle while results drain; the single result register sets this rate.
// Reset (synchronous, active low) returns the sequencer to idle and loads default limits.
// When the output stalls, the input is held off only while the result register is full
// and not being drained in the same cycle. The configuration port is always ready.
module ultrasonic_level_controller
    import ulc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Measurement phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // Configuration registers.
    logic [10:0] r_low_limit;
    logic [10:0] r_full_limit;
    logic [15:0] r_echo_timeout;
    logic [7:0]  r_ticks_per_unit;
    logic [7:0]  r_trigger_width;

    // Measurement state.
    logic [1:0]  r_phase,          n_phase;
    logic [7:0]  r_trigger_count,  n_trigger_count;
    logic [15:0] r_elapsed_us,     n_elapsed_us;
    logic [7:0]  r_prescale_count, n_prescale_count;
    logic [10:0] r_unit_count,     n_unit_count;
    logic        r_low_latched,    n_low_latched;
    logic        r_full_latched,   n_full_latched;
    logic        r_buzzer,         n_buzzer;
    logic        r_pump,           n_pump;

    // Result register.
    logic        r_out_valid;
    t_out_item   r_out,            n_out;

    logic        in_accept;
    logic [11:0] level_doubled;
    logic [10:0] level;
    logic [7:0]  prescale_inc;

    assign o_cfg_ready = 1'b1;
    // The result register can take a new result when empty or when it drains this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign prescale_inc  = r_prescale_count + 8'd1;
    assign level_doubled = {r_unit_count, 1'b0};

    // The level on a falling echo: zero at or past the timeout, else twice the units, saturated.
    always_comb begin
        if (r_elapsed_us >= r_echo_timeout) begin
            level = '0;
        end else if (level_doubled[11]) begin
            level = LEVEL_MAX;
        end else begin
            level = level_doubled[10:0];
        end
    end

    // Next state and the result of the current request, all in one pass.
    always_comb begin
        n_phase          = r_phase;
        n_trigger_count  = r_trigger_count;
        n_elapsed_us     = r_elapsed_us;
        n_prescale_count = r_prescale_count;
        n_unit_count     = r_unit_count;
        n_low_latched    = r_low_latched;
        n_full_latched   = r_full_latched;
        n_buzzer         = r_buzzer;
        n_pump           = r_pump;
        n_out.trigger_level = 1'b0;
        n_out.alert         = ALERT_NONE;
        n_out.level_valid   = 1'b0;
        n_out.level_value   = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_in_data.start_request) begin
                    n_phase             = PH_TRIG;
                    n_trigger_count     = 8'd1;
                    n_out.trigger_level = 1'b1;
                end
            end
            PH_TRIG: begin
                // A zero width behaves as one because the count starts at one.
                if (r_trigger_count >= r_trigger_width) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_trigger_count     = r_trigger_count + 8'd1;
                    n_out.trigger_level = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_in_data.echo_level) begin
                    n_phase      = PH_MEAS;
                    n_elapsed_us = 16'd1;
                    if (r_ticks_per_unit <= 8'd1) begin
                        n_prescale_count = '0;
                        n_unit_count     = 11'd1;
                    end else begin
                        n_prescale_count = 8'd1;
                        n_unit_count     = '0;
                    end
                end
            end
            PH_MEAS: begin
                if (i_in_data.echo_level) begin
                    if (r_elapsed_us != ELAPSED_MAX) begin
                        n_elapsed_us = r_elapsed_us + 16'd1;
                    end
                    if (prescale_inc >= r_ticks_per_unit) begin
                        n_prescale_count = '0;
                        if (r_unit_count != LEVEL_MAX) begin
                            n_unit_count = r_unit_count + 11'd1;
                        end
                    end else begin
                        n_prescale_count = prescale_inc;
                    end
                end else begin
                    n_phase           = PH_IDLE;
                    n_out.level_valid = 1'b1;
                    n_out.level_value = level;
                    // Latched alerts fire once per excursion; only an in-band reading
                    // clears them.
                    if (level < r_low_limit && !r_low_latched) begin
                        n_buzzer      = 1'b1;
                        n_pump        = 1'b1;
                        n_low_latched = 1'b1;
                        n_out.alert   = ALERT_LOW;
                    end else if (level > r_full_limit && !r_full_latched) begin
                        n_buzzer       = 1'b0;
                        n_pump         = 1'b0;
                        n_full_latched = 1'b1;
                        n_out.alert    = ALERT_FULL;
                    end else if (level >= r_low_limit && level <= r_full_limit) begin
                        n_buzzer       = 1'b0;
                        n_pump         = 1'b0;
                        n_low_latched  = 1'b0;
                        n_full_latched = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_out.buzzer_on = n_buzzer;
        n_out.pump_on   = n_pump;
        n_out.busy_res  = (n_phase != PH_IDLE);
    end

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit      <= RST_LOW_LIMIT;
            r_full_limit     <= RST_FULL_LIMIT;
            r_echo_timeout   <= RST_ECHO_TIMEOUT;
            r_ticks_per_unit <= RST_TICKS_PER_UNIT;
            r_trigger_width  <= RST_TRIGGER_WIDTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOW_LIMIT:      r_low_limit      <= i_cfg_data[10:0];
                CFG_FULL_LIMIT:     r_full_limit     <= i_cfg_data[10:0];
                CFG_ECHO_TIMEOUT:   r_echo_timeout   <= i_cfg_data;
                CFG_TICKS_PER_UNIT: r_ticks_per_unit <= i_cfg_data[7:0];
                CFG_TRIGGER_WIDTH:  r_trigger_width  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Measurement state advances only on accepted requests.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_trigger_count  <= '0;
            r_elapsed_us     <= '0;
            r_prescale_count <= '0;
            r_unit_count     <= '0;
            r_low_latched    <= 1'b0;
            r_full_latched   <= 1'b0;
            r_buzzer         <= 1'b0;
            r_pump           <= 1'b0;
        end else if (in_accept) begin
            r_phase          <= n_phase;
            r_trigger_count  <= n_trigger_count;
            r_elapsed_us     <= n_elapsed_us;
            r_prescale_count <= n_prescale_count;
            r_unit_count     <= n_unit_count;
            r_low_latched    <= n_low_latched;
            r_full_latched   <= n_full_latched;
            r_buzzer         <= n_buzzer;
            r_pump           <= n_pump;
        end
    end

    // Result register: valid is control, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // A completed measurement always leaves the block idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.level_valid) |-> !r_out.busy_res)
        else $error("completed measurement reported busy");

    // Alerts only come with a completed measurement.
    a_alert_with_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alert != ALERT_NONE) |-> r_out.level_valid)
        else $error("alert without a completed measurement");

    // Buzzer and pump are always switched together.
    a_buzzer_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer == r_pump)
        else $error("buzzer and pump disagree");

    // A start in idle enters the trigger phase.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_IDLE && i_in_data.start_request) |=>
            (r_phase == PH_TRIG && r_out.trigger_level))
        else $error("start request did not begin a trigger pulse");

    // While measuring, the echo width counter is never zero.
    a_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MEAS) |-> (r_elapsed_us != '0))
        else $error("echo width counter zero while measuring");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ulc_pkg::*;

    // A register index with no register behind it; writes to it must change nothing.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

    // The receiver's long hold-off, in cycles, and the reading counts that start it.
    localparam int unsigned LONG_HOLD       = 60;
    localparam int unsigned FIRST_HOLD_AT   = 400;
    localparam int unsigned SECOND_HOLD_AT  = 880;

    // Cycles with no accepted request, result or register write before giving up.
    localparam int unsigned WATCHDOG_LIMIT  = 1000;

    // Sequencer phases of the predictor.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TRIGGER,
        SEQ_LISTEN,
        SEQ_TIMING
    } t_seq_phase;

    // Clock, reset and every input of the block start at known values.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    t_in_item    in_data     = '0;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [15:0] cfg_data    = '0;

    logic        in_ready;
    logic        out_valid;
    t_out_item   out_data;
    logic        cfg_ready;

    // Ticks waiting to be offered, and the readings they are predicted to produce.
    t_in_item    pending_ticks[$];
    t_out_item   expected_readings[$];

    int unsigned ticks_queued   = 0;
    int unsigned ticks_taken    = 0;
    int unsigned readings_seen  = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    logic        in_taken       = 1'b0;

    // Idling control: the chance, in percent, that a burst of idle cycles starts.
    int unsigned snd_gap_pct    = 0;
    int unsigned rcv_gap_pct    = 0;
    int unsigned snd_gap_left   = 0;
    int unsigned rcv_hold_left  = 0;
    int unsigned long_holds     = 0;

    // Trigger width as last written, so that measurement sequences line up with it.
    logic [7:0]  plan_trig      = RST_TRIGGER_WIDTH;

    // Predictor copy of the configuration registers.
    logic [10:0] cfg_low;
    logic [10:0] cfg_full;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_tpu;
    logic [7:0]  cfg_trig;

    // Predictor copy of the ranging state.
    t_seq_phase  seq_phase;
    logic [7:0]  trig_cnt;
    logic [15:0] echo_us;
    logic [7:0]  presc;
    logic [10:0] units;
    logic        low_flag;
    logic        full_flag;
    logic        buzzer;
    logic        pump;

    ultrasonic_level_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Advances the predicted sequencer by one microsecond tick and returns the reading
    // that tick produces. The trigger runs for the programmed width, the block then
    // listens for the echo, times how long it stays high, and on its falling edge
    // turns the width into a level and runs the latched alarm logic.
    function automatic t_out_item ranging_step(t_in_item req);
        t_out_item   res;
        logic [11:0] doubled;
        res = '0;
        res.alert = ALERT_NONE;
        case (seq_phase)
            SEQ_IDLE: begin
                if (req.start_request) begin
                    seq_phase = SEQ_TRIGGER;
                    trig_cnt = 8'd1;
                    res.trigger_level = 1'b1;
                end
            end
            SEQ_TRIGGER: begin
                // A zero width compares the same way as a width of one.
                if (trig_cnt >= cfg_trig) begin
                    seq_phase = SEQ_LISTEN;
                end else begin
                    trig_cnt = trig_cnt + 8'd1;
                    res.trigger_level = 1'b1;
                end
            end
            SEQ_LISTEN: begin
                if (req.echo_level) begin
                    seq_phase = SEQ_TIMING;
                    echo_us = 16'd1;
                    units = '0;
                    presc = 8'd1;
                    if (presc >= cfg_tpu) begin
                        presc = '0;
                        units = 11'd1;
                    end
                end
            end
            default: begin
                if (req.echo_level) begin
                    // Both the microsecond count and the unit count stop at their tops.
                    if (echo_us != ELAPSED_MAX) echo_us = echo_us + 16'd1;
                    presc = presc + 8'd1;
                    if (presc >= cfg_tpu) begin
                        presc = '0;
                        if (units != LEVEL_MAX) units = units + 11'd1;
                    end
                end else begin
                    if (echo_us >= cfg_timeout) begin
                        res.level_value = '0;
                    end else begin
                        doubled = {units, 1'b0};
                        res.level_value = (doubled > 12'd2047) ? LEVEL_MAX : doubled[10:0];
                    end
                    res.level_valid = 1'b1;
                    // Alarm latches: each alert fires once until the level returns to
                    // the band between the two limits.
                    if (res.level_value < cfg_low && !low_flag) begin
                        buzzer = 1'b1;
                        pump = 1'b1;
                        low_flag = 1'b1;
                        res.alert = ALERT_LOW;
                    end else if (res.level_value > cfg_full && !full_flag) begin
                        buzzer = 1'b0;
                        pump = 1'b0;
                        full_flag = 1'b1;
                        res.alert = ALERT_FULL;
                    end else if (res.level_value >= cfg_low && res.level_value <= cfg_full) begin
                        buzzer = 1'b0;
                        pump = 1'b0;
                        low_flag = 1'b0;
                        full_flag = 1'b0;
                    end
                    seq_phase = SEQ_IDLE;
                end
            end
        endcase
        res.buzzer_on = buzzer;
        res.pump_on = pump;
        res.busy_res = (seq_phase != SEQ_IDLE);
        return res;
    endfunction

    // Monitor: samples every handshake at the rising edge, predicts accepted requests,
    // applies register writes to the predictor and checks each reading in order.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            cfg_low = RST_LOW_LIMIT;
            cfg_full = RST_FULL_LIMIT;
            cfg_timeout = RST_ECHO_TIMEOUT;
            cfg_tpu = RST_TICKS_PER_UNIT;
            cfg_trig = RST_TRIGGER_WIDTH;
            seq_phase = SEQ_IDLE;
            trig_cnt = '0;
            echo_us = '0;
            presc = '0;
            units = '0;
            low_flag = 1'b0;
            full_flag = 1'b0;
            buzzer = 1'b0;
            pump = 1'b0;
        end else begin
            in_taken <= in_valid && in_ready;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOW_LIMIT:      cfg_low = cfg_data[10:0];
                    CFG_FULL_LIMIT:     cfg_full = cfg_data[10:0];
                    CFG_ECHO_TIMEOUT:   cfg_timeout = cfg_data;
                    CFG_TICKS_PER_UNIT: cfg_tpu = cfg_data[7:0];
                    CFG_TRIGGER_WIDTH:  cfg_trig = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                expected_readings.push_back(ranging_step(in_data));
                ticks_taken++;
            end

            if (out_valid && out_ready) begin
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d arrived with no request pending", readings_seen);
                end else begin
                    want = expected_readings.pop_front();
                    if (out_data.trigger_level !== want.trigger_level ||
                        out_data.buzzer_on     !== want.buzzer_on     ||
                        out_data.pump_on       !== want.pump_on       ||
                        out_data.alert         !== want.alert         ||
                        out_data.level_valid   !== want.level_valid   ||
                        out_data.level_value   !== want.level_value   ||
                        out_data.busy_res      !== want.busy_res) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("reading %0d expected trig=%b buz=%b pump=%b alert=%0d",
                                     readings_seen, want.trigger_level, want.buzzer_on,
                                     want.pump_on, want.alert);
                            $display("    valid=%b level=%0d busy=%b", want.level_valid,
                                     want.level_value, want.busy_res);
                            $display("    got trig=%b buz=%b pump=%b alert=%0d",
                                     out_data.trigger_level, out_data.buzzer_on,
                                     out_data.pump_on, out_data.alert);
                            $display("    valid=%b level=%0d busy=%b", out_data.level_valid,
                                     out_data.level_value, out_data.busy_res);
                        end
                    end
                end
                readings_seen++;
            end

            // Watchdog: any handshake at all counts as progress.
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Driver: offers the next pending tick at the falling edge. Valid is only dropped
    // after an acceptance, so a request never changes while it waits for ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (snd_gap_left > 0) begin
                snd_gap_left--;
                in_valid <= 1'b0;
            end else if (pending_ticks.size() != 0 && snd_gap_pct != 0 &&
                         $urandom_range(99) < snd_gap_pct) begin
                snd_gap_left = $urandom_range(0, 7);
                in_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                in_data <= pending_ticks.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready with random hold-off bursts, plus two long holds that let the
    // result register fill so that the block has to stall its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            out_ready <= 1'b0;
        end else if (long_holds < 2 &&
                     readings_seen >= ((long_holds == 0) ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
            long_holds++;
            rcv_hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (rcv_gap_pct != 0 && $urandom_range(99) < rcv_gap_pct) begin
            rcv_hold_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic bit rand_bit();
        return 1'($urandom_range(1));
    endfunction

    task automatic queue_tick(bit start, bit echo);
        t_in_item t;
        t.start_request = start;
        t.echo_level = echo;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // One well-formed measurement: start, the trigger ticks, a wait with the echo low,
    // the echo high for the given width, then the falling edge. With noise on, the
    // start bit toggles while busy and the echo toggles during the trigger, both of
    // which the block has to ignore.
    task automatic queue_measurement(int unsigned settle, int unsigned width, bit noisy);
        int unsigned k;
        int unsigned trig_len;
        trig_len = (plan_trig == 0) ? 1 : plan_trig;
        queue_tick(1'b1, noisy & rand_bit());
        for (k = 0; k < trig_len; k++)
            queue_tick(noisy & rand_bit(), noisy & rand_bit());
        for (k = 0; k < settle; k++)
            queue_tick(noisy & rand_bit(), 1'b0);
        for (k = 0; k < width; k++)
            queue_tick(noisy & rand_bit(), 1'b1);
        queue_tick(noisy & rand_bit(), 1'b0);
    endtask

    // Called at a falling edge; leaves the write request high for the next write.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        if (idx == CFG_TRIGGER_WIDTH) plan_trig = val[7:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every queued tick has been taken and every reading has come back.
    task automatic settle_block();
        do @(negedge i_clk);
        while (ticks_taken != ticks_queued || expected_readings.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Small random limits so that readings fall below, inside and above the band,
    // and short timeouts so that long echoes read as zero.
    task automatic random_setup();
        logic [10:0] lo;
        lo = 11'($urandom_range(0, 40));
        write_reg(CFG_LOW_LIMIT, {5'd0, lo});
        if ($urandom_range(4) == 0)
            write_reg(CFG_FULL_LIMIT, 16'($urandom_range(0, lo)));
        else
            write_reg(CFG_FULL_LIMIT, 16'(lo + $urandom_range(0, 60)));
        write_reg(CFG_ECHO_TIMEOUT, 16'($urandom_range(8, 200)));
        write_reg(CFG_TICKS_PER_UNIT, 16'($urandom_range(1, 4)));
        write_reg(CFG_TRIGGER_WIDTH, 16'($urandom_range(1, 6)));
        cfg_valid <= 1'b0;
        snd_gap_pct = 15 * $urandom_range(2);
        rcv_gap_pct = 15 * $urandom_range(2);
    endtask

    // Mostly complete measurements with random content; the rest is pure noise or a
    // start followed by a sequence that breaks off early.
    task automatic random_phase(int unsigned count);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        target = ticks_queued + count;
        while (ticks_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 40);
                queue_measurement($urandom_range(0, 4), len, rand_bit());
            end else if (pick < 90) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) queue_tick(rand_bit(), rand_bit());
            end else begin
                len = $urandom_range(1, 5);
                queue_tick(1'b1, 1'b0);
                for (k = 0; k < len; k++) queue_tick(rand_bit(), rand_bit());
            end
        end
    endtask

    initial begin
        int unsigned n;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limits: an echo of three units reads 6, under the low limit.
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_measurement(2, 177, 1'b0);
        settle_block();

        // Tight limits for the directed cases: low alert, full alert while the low
        // latch is set, a width right at the timeout reading zero, then back in band.
        write_reg(CFG_TRIGGER_WIDTH, 16'd1);
        write_reg(CFG_TICKS_PER_UNIT, 16'd1);
        write_reg(CFG_ECHO_TIMEOUT, 16'd6);
        write_reg(CFG_LOW_LIMIT, 16'd4);
        write_reg(CFG_FULL_LIMIT, 16'd8);
        cfg_valid <= 1'b0;
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_measurement(1, 1, 1'b1);
        queue_measurement(0, 5, 1'b1);
        queue_measurement(0, 6, 1'b0);
        queue_measurement(0, 3, 1'b0);
        settle_block();

        // Zero trigger width and tick count act as one, a zero timeout reads zero
        // every time, upper data bits are dropped and a spare index does nothing.
        write_reg(CFG_TRIGGER_WIDTH, 16'hFF00);
        write_reg(CFG_TICKS_PER_UNIT, 16'h0100);
        write_reg(CFG_ECHO_TIMEOUT, 16'h0000);
        write_reg(CFG_SPARE_INDEX, 16'h1234);
        write_reg(CFG_LOW_LIMIT, 16'hFFFF);
        write_reg(CFG_FULL_LIMIT, 16'hF800);
        cfg_valid <= 1'b0;
        queue_measurement(0, 2, 1'b1);
        queue_measurement(1, 3, 1'b1);
        settle_block();

        // Widest trigger and slowest unit: an echo of 300 ticks reads as a single unit.
        write_reg(CFG_TRIGGER_WIDTH, 16'd255);
        write_reg(CFG_TICKS_PER_UNIT, 16'd255);
        write_reg(CFG_ECHO_TIMEOUT, 16'hFFFF);
        write_reg(CFG_LOW_LIMIT, 16'd0);
        write_reg(CFG_FULL_LIMIT, 16'd2047);
        cfg_valid <= 1'b0;
        queue_measurement(1, 300, 1'b1);
        settle_block();

        // Bulk of the run: several random settings, each with its own idling mix.
        for (n = 0; n < 6; n++) begin
            random_setup();
            random_phase(30);
            settle_block();
        end

        // Closing stretch with random idling off on both sides.
        random_setup();
        snd_gap_pct = 0;
        rcv_gap_pct = 0;
        random_phase(60);
        settle_block();

        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ulc_pkg.sv
design/ultrasonic_level_controller.sv
verif/tb_top.sv
